/* hw/rtl/lcur_pkg.sv */
// Shared types and constants for the lagged combined uniform generator.
// Used by lcur_cell, lcur_frac and lagged_combined_uniform_rng_unit.
package lcur_pkg;

  // Field widths.
  localparam int WORD_W  = 30;
  localparam int MIX_W   = 25;
  localparam int FRAC_W  = 32;
  localparam int ENTRY_W = 7;
  localparam int KIND_W  = 2;

  // Default lags for the ring.
  localparam int LONG_LAG_DEF  = 101;
  localparam int SHORT_LAG_DEF = 64;

  // Ring modulus in the widths where it is needed.
  localparam logic [WORD_W-1:0] RING_MOD    = 30'd1000009711;
  localparam logic [32:0]       RING_MOD_33 = 33'd1000009711;
  localparam logic [63:0]       RING_MOD_64 = 64'd1000009711;

  // Reciprocal floor(2^62 / M); the fraction is (r * RECIP) >> 30 plus a correction.
  localparam logic [32:0] RECIP = 33'((64'd1 << 62) / RING_MOD_64);

  // Multiplier of the mixer generator.
  localparam logic [MIX_W-1:0] MIX_MUL = 25'd37;

  // Request kinds.
  localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RING  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_MIXER = 2'd2;

  // One request beat.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ENTRY_W-1:0] entry;
    logic [WORD_W-1:0]  value;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [WORD_W-1:0] lag_value;
    logic [MIX_W-1:0]  mixer_value;
    logic [FRAC_W-1:0] uniform;
  } out_item_t;

  // A finished ring step handed to the fraction pipeline.
  typedef struct packed {
    logic [WORD_W-1:0] r;
    logic [MIX_W-1:0]  k;
  } draw_t;

  // Per-cell control of the ring chain.
  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctrl_t;

endpackage

/* hw/rtl/lcur_cell.sv */
// One word of the lag ring: takes its neighbor's word on a shift, or a load word.
// Depends on lcur_pkg for the word width and the control struct.
module lcur_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  lcur_pkg::cell_ctrl_t       ctrl,
  input  logic [lcur_pkg::WORD_W-1:0] shift_in,
  input  logic [lcur_pkg::WORD_W-1:0] write_data,
  output logic [lcur_pkg::WORD_W-1:0] word
);

  // A load into this cell wins over a shift; the two never meet in one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      word <= '0;
    end else if (ctrl.write) begin
      word <= write_data;
    end else if (ctrl.shift) begin
      word <= shift_in;
    end
  end

endmodule

/* hw/rtl/lcur_frac.sv */
// Pipeline that turns a ring residue and mixer state into the 0.32 fraction.
// Depends on lcur_pkg for the draw and result types and the reciprocal constant.
module lcur_frac (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  lcur_pkg::draw_t     draw,
  output logic                result_valid,
  input  logic                result_stall,
  output lcur_pkg::out_item_t result
);

  typedef struct packed {
    logic [lcur_pkg::FRAC_W-1:0] q0;
    logic [lcur_pkg::WORD_W-1:0] r;
    logic [lcur_pkg::MIX_W-1:0]  k;
  } est_t;

  typedef struct packed {
    logic [lcur_pkg::FRAC_W-1:0] mlow;
    logic [lcur_pkg::FRAC_W-1:0] q0;
    logic [lcur_pkg::WORD_W-1:0] r;
    logic [lcur_pkg::MIX_W-1:0]  k;
  } prod_t;

  typedef struct packed {
    logic                        fix;
    logic [lcur_pkg::FRAC_W-1:0] q0;
    logic [lcur_pkg::WORD_W-1:0] r;
    logic [lcur_pkg::MIX_W-1:0]  k;
  } corr_t;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;
  lcur_pkg::draw_t s1;
  est_t            s2;
  prod_t           s3;
  corr_t           s4;

  logic [62:0]                 recip_prod;
  logic [lcur_pkg::FRAC_W-1:0] mod_prod;
  logic [lcur_pkg::FRAC_W-1:0] rem;
  logic [lcur_pkg::FRAC_W-1:0] frac_sum;

  // A stage moves on when the one after it is empty or moving.
  assign rdy4     = !result_valid || !result_stall;
  assign rdy3     = !v4 || rdy4;
  assign rdy2     = !v3 || rdy3;
  assign rdy1     = !v2 || rdy2;
  assign in_ready = !v1 || rdy1;

  // Quotient estimate from the reciprocal; it is exact or one low.
  assign recip_prod = 63'(s1.r) * 63'(lcur_pkg::RECIP);

  // Low word of q0 * M; the remainder r * 2^32 - q0 * M is its negation.
  assign mod_prod = s2.q0 * 32'(lcur_pkg::RING_MOD);
  assign rem      = 32'd0 - s3.mlow;

  // Final sum with the correction as carry in, wrapped to 32 bits.
  assign frac_sum = s4.q0 + {s4.k, 7'd0} + 32'(s4.fix);

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1           <= 1'b0;
      v2           <= 1'b0;
      v3           <= 1'b0;
      v4           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (in_ready) v1 <= in_valid;
      if (rdy1) v2 <= v1;
      if (rdy2) v3 <= v2;
      if (rdy3) v4 <= v3;
      if (rdy4) result_valid <= v4;
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1 <= draw;
    end
    if (rdy1 && v1) begin
      s2.q0 <= recip_prod[61:30];
      s2.r  <= s1.r;
      s2.k  <= s1.k;
    end
    if (rdy2 && v2) begin
      s3.mlow <= mod_prod;
      s3.q0   <= s2.q0;
      s3.r    <= s2.r;
      s3.k    <= s2.k;
    end
    if (rdy3 && v3) begin
      s4.fix <= (rem >= 32'(lcur_pkg::RING_MOD));
      s4.q0  <= s3.q0;
      s4.r   <= s3.r;
      s4.k   <= s3.k;
    end
    if (rdy4 && v4) begin
      result.lag_value   <= s4.r;
      result.mixer_value <= s4.k;
      result.uniform     <= (frac_sum == '0) ? 32'd1 : frac_sum;
    end
  end

endmodule

/* hw/rtl/lagged_combined_uniform_rng_unit.sv */
// Top level of the lagged combined uniform generator: ring of cells, mixer, control.
// Depends on lcur_pkg, lcur_cell and lcur_frac.
//
// Use: the request channel (request_valid, request_stall, request) carries draw
// beats and load beats; the result channel (result_valid, result_stall, result)
// carries one beat per draw and nothing for loads or unused kinds.
// Throughput: one request per cycle while request_stall is low. A draw's ring step
// and mixer step finish in the cycle it is taken; the ring's lagged word is a fixed
// cell of the chain, so a draw may follow a draw in the next cycle.
// A draw's result beat comes out of the fraction pipeline: input register,
// reciprocal multiply, remainder multiply, correction compare, final add.
// A mixer load resets the ring position by rotating the chain one cell a cycle
// until position zero sits at the head: request_stall stays high after such a
// load until the rotation ends.
// Reset: synchronous; ring words, position and mixer clear to zero and the
// pipeline empties.
// Receiver stall: the result beat holds; the pipeline fills behind it and then
// request_stall rises for draws, while loads are still taken.
module lagged_combined_uniform_rng_unit #(
  parameter int LONG_LAG  = lcur_pkg::LONG_LAG_DEF,
  parameter int SHORT_LAG = lcur_pkg::SHORT_LAG_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                request_valid,
  output logic                request_stall,
  input  lcur_pkg::in_item_t  request,
  output logic                result_valid,
  input  logic                result_stall,
  output lcur_pkg::out_item_t result
);

  localparam int PosW   = $clog2(LONG_LAG);
  localparam int LagIdx = (LONG_LAG - (SHORT_LAG % LONG_LAG)) % LONG_LAG;
  localparam logic [PosW-1:0] LastPos = PosW'(LONG_LAG - 1);

  logic [lcur_pkg::WORD_W-1:0] word [LONG_LAG];
  logic [PosW-1:0]             pos;
  logic [PosW-1:0]             pos_inc;
  logic                        realign;
  logic [lcur_pkg::MIX_W-1:0]  mixer;
  logic [lcur_pkg::MIX_W-1:0]  mix_step;
  logic [lcur_pkg::MIX_W-1:0]  mix_next;

  logic accept, draw_fire, ring_fire, draw_ready;
  logic entry_ok;
  logic [7:0]      ent8, pos8, off8;
  logic [PosW-1:0] offset;

  logic [lcur_pkg::WORD_W-1:0] val_red;
  logic [lcur_pkg::WORD_W-1:0] lag_word, cur_word;
  logic [32:0]                 sum;
  logic [2:0]                  nsel;
  logic [32:0]                 diff;
  logic [lcur_pkg::WORD_W-1:0] r_new;
  lcur_pkg::draw_t             draw;

  // Handshake: draws need room in the fraction pipeline; nothing enters while rotating.
  assign request_stall = realign || ((request.kind == lcur_pkg::KIND_DRAW) && !draw_ready);
  assign accept    = request_valid && !request_stall;
  assign draw_fire = accept && (request.kind == lcur_pkg::KIND_DRAW);
  assign ring_fire = accept && (request.kind == lcur_pkg::KIND_RING);

  // Next position, wrapping at the ring length.
  assign pos_inc = (pos == LastPos) ? '0 : pos + 1'b1;

  // Cell that holds a loaded entry: its distance ahead of the current position.
  assign ent8     = {1'b0, request.entry};
  assign pos8     = 8'(pos);
  assign entry_ok = ent8 < 8'(LONG_LAG);
  assign off8     = (ent8 >= pos8) ? (ent8 - pos8) : (ent8 + 8'(LONG_LAG) - pos8);
  assign offset   = off8[PosW-1:0];

  // Loaded words are kept reduced below the modulus.
  assign val_red = (request.value >= lcur_pkg::RING_MOD) ?
                   (request.value - lcur_pkg::RING_MOD) : request.value;

  // Ring step: r = (-(2a + 5b)) mod M = ceil(sum / M) * M - sum.
  assign lag_word = word[LagIdx];
  assign cur_word = word[0];
  assign sum = {2'b0, lag_word, 1'b0} + {1'b0, cur_word, 2'b0} + {3'b0, cur_word};

  always_comb begin
    nsel = '0;
    for (int j = 0; j < 7; j++) begin
      if (sum > (lcur_pkg::RING_MOD_33 * 33'(j))) nsel = 3'(j + 1);
    end
  end

  assign diff  = (33'(nsel) * lcur_pkg::RING_MOD_33) - sum;
  assign r_new = diff[lcur_pkg::WORD_W-1:0];

  // Mixer step, taken twice when it lands on zero (the second step gives one).
  assign mix_step = (mixer * lcur_pkg::MIX_MUL) + lcur_pkg::MIX_W'(1);
  assign mix_next = (mix_step == '0) ? lcur_pkg::MIX_W'(1) : mix_step;

  // Chain of ring cells; cell i holds the word at position pos + i.
  for (genvar i = 0; i < LONG_LAG; i++) begin : g_cell
    lcur_pkg::cell_ctrl_t        ctrl;
    logic [lcur_pkg::WORD_W-1:0] shift_in;

    assign ctrl.shift = realign || draw_fire;
    assign ctrl.write = ring_fire && entry_ok && (offset == PosW'(i));

    if (i == LONG_LAG - 1) begin : g_tail
      assign shift_in = draw_fire ? r_new : word[0];
    end else begin : g_body
      assign shift_in = word[i + 1];
    end

    lcur_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .shift_in   (shift_in),
      .write_data (val_red),
      .word       (word[i])
    );
  end

  // Position, rotation and mixer state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos     <= '0;
      realign <= 1'b0;
      mixer   <= '0;
    end else if (realign) begin
      pos     <= pos_inc;
      realign <= (pos_inc != '0);
    end else if (accept) begin
      case (request.kind)
        lcur_pkg::KIND_DRAW: begin
          pos   <= pos_inc;
          mixer <= mix_next;
        end
        lcur_pkg::KIND_MIXER: begin
          mixer   <= request.value[lcur_pkg::MIX_W-1:0];
          realign <= (pos != '0);
        end
        default: begin
        end
      endcase
    end
  end

  // Hand the finished step to the fraction pipeline.
  assign draw.r = r_new;
  assign draw.k = mix_next;

  lcur_frac u_frac (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (draw_fire),
    .in_ready     (draw_ready),
    .draw         (draw),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

`ifndef NO_ASSERTIONS
  a_realign_blocks: assert property (@(posedge clk) disable iff (rst)
    realign |-> request_stall)
    else $error("request taken while the ring rotates");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= LastPos)
    else $error("ring position beyond the ring");

  a_head_reduced: assert property (@(posedge clk) disable iff (rst)
    cur_word < lcur_pkg::RING_MOD)
    else $error("ring word not reduced");

  a_mixer_load_rotates: assert property (@(posedge clk) disable iff (rst)
    (accept && (request.kind == lcur_pkg::KIND_MIXER) && (pos != '0)) |=> realign)
    else $error("mixer load did not start the rotation");

  a_uniform_nonzero: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.uniform != '0) && (result.mixer_value != '0)))
    else $error("zero fraction or mixer in a result beat");
`endif

endmodule

/* verif/lagged_combined_uniform_rng_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench for lagged_combined_uniform_rng_unit: directed and random request beats
// against an in-bench prediction of the ring, the mixer and the fraction.
// Depends on lcur_pkg and the unit's RTL only.
module lagged_combined_uniform_rng_unit_tb;

  localparam int          RING_LEN    = lcur_pkg::LONG_LAG_DEF;
  localparam int          LAG_BACK    = lcur_pkg::SHORT_LAG_DEF;
  localparam logic [63:0] MODULUS     = lcur_pkg::RING_MOD_64;
  localparam logic [1:0]  KIND_SPARE  = 2'd3;
  localparam int          QUIET_LIMIT = 2000;
  localparam int          DRAIN_WAIT  = 16;

  typedef enum {STALL_NONE, STALL_PERIODIC, STALL_RANDOM} stall_style_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                request_valid;
  logic                request_stall;
  lcur_pkg::in_item_t  request;
  logic                result_valid;
  logic                result_stall = 1'b0;
  lcur_pkg::out_item_t result;

  // Predicted generator state.
  logic [lcur_pkg::WORD_W-1:0] ring_words [RING_LEN];
  logic [6:0]                  ring_pos;
  logic [lcur_pkg::MIX_W-1:0]  mix_state;
  lcur_pkg::out_item_t         draws_due [$];
  lcur_pkg::out_item_t         due;

  int mismatches  = 0;
  int quiet_cycles = 0;

  // Sender burst shaping and receiver stall pattern.
  int           burst_left = 0;
  bit           steady = 1'b0;
  stall_style_t stall_style = STALL_NONE;
  int           stall_left = 0;
  int           stall_period = 2;
  int           stall_duty = 1;

  lagged_combined_uniform_rng_unit DUT (
    .clk           (clk),
    .rst           (rst),
    .request_valid (request_valid),
    .request_stall (request_stall),
    .request       (request),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .result        (result)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // One step of the mixer generator, k = 37k + 1 mod 2^25.
  function automatic logic [lcur_pkg::MIX_W-1:0] mix_next(logic [lcur_pkg::MIX_W-1:0] k);
    return k * lcur_pkg::MIX_MUL + 25'd1;
  endfunction

  // Inverse of the mixer multiplier mod 2^25, by Newton iteration.
  function automatic logic [lcur_pkg::MIX_W-1:0] mix_mul_inverse();
    logic [lcur_pkg::MIX_W-1:0] x;
    x = lcur_pkg::MIX_MUL;
    repeat (4) x = x * (25'd2 - lcur_pkg::MIX_MUL * x);
    return x;
  endfunction

  // Advance the predicted ring and mixer by one draw and form its result beat.
  function automatic lcur_pkg::out_item_t take_draw();
    lcur_pkg::out_item_t         beat;
    int                          cur;
    int                          lagged;
    logic [63:0]                 a;
    logic [63:0]                 b;
    logic [63:0]                 sum;
    logic [63:0]                 r;
    logic [63:0]                 scaled;
    logic [lcur_pkg::MIX_W-1:0]  k;
    logic [lcur_pkg::FRAC_W-1:0] frac;
    cur    = int'(ring_pos);
    lagged = (cur + RING_LEN - (LAG_BACK % RING_LEN)) % RING_LEN;
    a   = 64'(ring_words[lagged]) % MODULUS;
    b   = 64'(ring_words[cur]) % MODULUS;
    sum = (2 * a + 5 * b) % MODULUS;
    r   = (MODULUS - sum) % MODULUS;
    ring_words[cur] = r[lcur_pkg::WORD_W-1:0];
    ring_pos = 7'((cur + 1) % RING_LEN);
    // A mixer step that lands on zero is taken again.
    k = mix_next(mix_state);
    if (k == '0) begin
      k = mix_next(k);
    end
    mix_state = k;
    scaled = (r << 32) / MODULUS;
    frac = scaled[31:0] + {k, 7'd0};
    if (frac == '0) begin
      frac = 32'd1;
    end
    beat.lag_value   = r[lcur_pkg::WORD_W-1:0];
    beat.mixer_value = k;
    beat.uniform     = frac;
    return beat;
  endfunction

  function automatic lcur_pkg::in_item_t make_item(logic [1:0] kind, logic [6:0] entry,
                                                   logic [lcur_pkg::WORD_W-1:0] value);
    lcur_pkg::in_item_t beat;
    beat.kind  = kind;
    beat.entry = entry;
    beat.value = value;
    return beat;
  endfunction

  // Ring words are mostly proper residues, now and then any 30-bit value.
  function automatic logic [lcur_pkg::WORD_W-1:0] random_ring_word();
    if ($urandom_range(0, 9) == 0) begin
      return 30'($urandom);
    end
    return 30'($urandom_range(0, lcur_pkg::RING_MOD - 1));
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10) begin
        $display("result %s mismatch: expected %0d, got %0d", name, want, got);
      end
      mismatches++;
    end
  endfunction

  // Send one request beat; the sender works in bursts, with random gaps between them unless steady is set.
  task automatic send_item(input lcur_pkg::in_item_t beat);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (steady) begin
        gap = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        gap = $urandom_range(5, 30);
      end else begin
        gap = $urandom_range(0, 3);
      end
      repeat (gap) begin
        @(negedge clk);
        request_valid = 1'b0;
        request = lcur_pkg::in_item_t'({$urandom, $urandom});
      end
    end
    burst_left--;
    @(negedge clk);
    request_valid = 1'b1;
    request = beat;
    @(posedge clk);
    while (request_stall) @(posedge clk);
  endtask

  // Hold off the sender until every predicted result beat has come back.
  task automatic wait_drained();
    @(negedge clk);
    request_valid = 1'b0;
    while (draws_due.size() != 0) @(posedge clk);
  endtask

  // Draws from the all-zero ring after reset: residue zero, fraction from the mixer.
  task automatic test_unloaded_ring();
    repeat (2) send_item(make_item(lcur_pkg::KIND_DRAW, 7'($urandom), 30'($urandom)));
  endtask

  // Extreme field values, residues not below M, out-of-range entries, the spare kind.
  task automatic test_ring_extremes();
    send_item(make_item(lcur_pkg::KIND_MIXER, 7'd0, 30'd0));
    send_item(make_item(lcur_pkg::KIND_RING, 7'd0, 30'h3FFF_FFFF));
    send_item(make_item(lcur_pkg::KIND_RING, 7'(RING_LEN - LAG_BACK), lcur_pkg::RING_MOD));
    send_item(make_item(lcur_pkg::KIND_RING, 7'(RING_LEN - 1), lcur_pkg::RING_MOD - 30'd1));
    send_item(make_item(lcur_pkg::KIND_RING, 7'(RING_LEN), 30'd0));
    send_item(make_item(lcur_pkg::KIND_RING, 7'h7F, 30'h3FFF_FFFF));
    send_item(make_item(KIND_SPARE, 7'h7F, 30'h3FFF_FFFF));
    repeat (2) send_item(make_item(lcur_pkg::KIND_DRAW, 7'h7F, 30'h3FFF_FFFF));
  endtask

  // A wide mixer load whose next step is zero, so the step is taken twice.
  task automatic test_mixer_wrap();
    logic [lcur_pkg::MIX_W-1:0] k0;
    k0 = 25'd0 - mix_mul_inverse();
    send_item(make_item(lcur_pkg::KIND_MIXER, 7'($urandom), {5'b10101, k0}));
    repeat (2) send_item(make_item(lcur_pkg::KIND_DRAW, 7'($urandom), 30'($urandom)));
  endtask

  // Seed the ring and mixer so that the combined fraction wraps to exactly zero.
  task automatic test_zero_fraction();
    logic [63:0]                r;
    logic [63:0]                scaled;
    logic [63:0]                half;
    logic [lcur_pkg::MIX_W-1:0] k;
    logic [lcur_pkg::MIX_W-1:0] v;
    r = 64'($urandom_range(1, lcur_pkg::RING_MOD - 1));
    scaled = (r << 32) / MODULUS;
    while (scaled[6:0] != 7'd0) begin
      r = (r == MODULUS - 1) ? 64'd1 : r + 64'd1;
      scaled = (r << 32) / MODULUS;
    end
    // The mixer must then supply the rest of 2^32.
    k = 25'((64'h1_0000_0000 - scaled) >> 7);
    v = (k - 25'd1) * mix_mul_inverse();
    // With the current word zero, twice the lagged word must be M - r.
    half = MODULUS - r;
    if (half[0]) begin
      half = half + MODULUS;
    end
    half = half >> 1;
    send_item(make_item(lcur_pkg::KIND_RING, 7'd0, 30'd0));
    send_item(make_item(lcur_pkg::KIND_RING, 7'(RING_LEN - LAG_BACK),
                        half[lcur_pkg::WORD_W-1:0]));
    send_item(make_item(lcur_pkg::KIND_MIXER, 7'($urandom), {5'($urandom), v}));
    send_item(make_item(lcur_pkg::KIND_DRAW, 7'($urandom), 30'($urandom)));
  endtask

  // A ring load between draws leaves the position where it was.
  task automatic test_ring_load_position();
    send_item(make_item(lcur_pkg::KIND_DRAW, 7'($urandom), 30'($urandom)));
    send_item(make_item(lcur_pkg::KIND_RING, 7'd2, random_ring_word()));
    repeat (2) send_item(make_item(lcur_pkg::KIND_DRAW, 7'($urandom), 30'($urandom)));
  endtask

  // Full reseed, then chunks of mostly draws mixed with loads and noise.
  task automatic test_random_stream();
    int useful;
    int roll;
    send_item(make_item(lcur_pkg::KIND_MIXER, 7'($urandom), 30'($urandom)));
    for (int i = 0; i < RING_LEN; i++) begin
      send_item(make_item(lcur_pkg::KIND_RING, 7'(i), random_ring_word()));
    end
    for (int chunk = 0; chunk < 8; chunk++) begin
      steady = (chunk % 3 == 1);
      if (chunk == 2 || chunk == 6) begin
        wait_drained();
      end
      useful = 0;
      while (useful < 60) begin
        roll = $urandom_range(0, 99);
        if (roll < 78) begin
          send_item(make_item(lcur_pkg::KIND_DRAW, 7'($urandom), 30'($urandom)));
          useful++;
        end else if (roll < 90) begin
          if ($urandom_range(0, 4) == 0) begin
            send_item(make_item(lcur_pkg::KIND_RING, 7'($urandom_range(RING_LEN, 127)),
                                30'($urandom)));
          end else begin
            send_item(make_item(lcur_pkg::KIND_RING, 7'($urandom_range(0, RING_LEN - 1)),
                                random_ring_word()));
            useful++;
          end
        end else if (roll < 93) begin
          send_item(make_item(lcur_pkg::KIND_MIXER, 7'($urandom), 30'($urandom)));
          useful++;
        end else begin
          send_item(make_item(KIND_SPARE, 7'($urandom), 30'($urandom)));
        end
      end
    end
    steady = 1'b0;
  endtask

  // Receiver stall pattern: style, period and duty chosen at random, re-rolled when stall_left runs out.
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_style  = stall_style_t'($urandom_range(0, 2));
      stall_period = $urandom_range(2, 12);
      stall_duty   = $urandom_range(1, stall_period - 1);
      stall_left   = $urandom_range(40, 160);
    end
    stall_left--;
    case (stall_style)
      STALL_NONE: begin
        result_stall = 1'b0;
      end
      STALL_PERIODIC: begin
        result_stall = (stall_left % stall_period) < stall_duty;
      end
      default: begin
        result_stall = ($urandom_range(0, 2) == 0);
      end
    endcase
  end

  // Check each result beat against the oldest prediction, then predict from the request beat.
  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RING_LEN; i++) begin
        ring_words[i] = '0;
      end
      ring_pos  = '0;
      mix_state = '0;
      draws_due.delete();
    end else begin
      if (result_valid && !result_stall) begin
        if (draws_due.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result beat: %0d %0d %0d",
                     result.lag_value, result.mixer_value, result.uniform);
          end
          mismatches++;
        end else begin
          due = draws_due.pop_front();
          check_field("lag_value", 32'(due.lag_value), 32'(result.lag_value));
          check_field("mixer_value", 32'(due.mixer_value), 32'(result.mixer_value));
          check_field("uniform", due.uniform, result.uniform);
        end
      end
      if (request_valid && !request_stall) begin
        case (request.kind)
          lcur_pkg::KIND_DRAW: begin
            draws_due.insert(draws_due.size(), take_draw());
          end
          lcur_pkg::KIND_RING: begin
            if (request.entry < RING_LEN) begin
              ring_words[request.entry] = request.value;
            end
          end
          lcur_pkg::KIND_MIXER: begin
            mix_state = request.value[lcur_pkg::MIX_W-1:0];
            ring_pos  = '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Watchdog: too long without any beat on either channel ends the run.
  always @(posedge clk) begin
    if (!rst) begin
      if ((request_valid && !request_stall) || (result_valid && !result_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout with %0d result beats outstanding", draws_due.size());
        $display("lagged_combined_uniform_rng_unit_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    request_valid = 1'b0;
    request = '0;
    repeat (9) @(negedge clk);
    rst = 1'b0;

    test_unloaded_ring();
    test_ring_extremes();
    test_mixer_wrap();
    test_zero_fraction();
    test_ring_load_position();
    test_random_stream();

    wait_drained();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && draws_due.size() == 0) begin
      $display("lagged_combined_uniform_rng_unit_tb: done, clean");
    end else begin
      $display("lagged_combined_uniform_rng_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/lcur_pkg.sv
hw/rtl/lcur_cell.sv
hw/rtl/lcur_frac.sv
hw/rtl/lagged_combined_uniform_rng_unit.sv
verif/lagged_combined_uniform_rng_unit_tb.sv
